FILE: hdl/sqlts_pkg.sv
package sqlts_pkg;

   // One input item: a text byte, or the end marker.
   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   // One result item: a token.
   typedef struct packed {
      logic [4:0]  token_kind;
      logic [15:0] token_start;
      logic [15:0] token_length;
      logic [7:0]  single_char;
      logic        last_of_run;
   } rsp_type;

   // Token kinds.
   localparam logic [4:0] KIND_END     = 5'd0;
   localparam logic [4:0] KIND_IDENT   = 5'd1;
   localparam logic [4:0] KIND_NUMBER  = 5'd2;
   localparam logic [4:0] KIND_STRING  = 5'd3;
   localparam logic [4:0] KIND_LPAREN  = 5'd4;
   localparam logic [4:0] KIND_RPAREN  = 5'd5;
   localparam logic [4:0] KIND_COMMA   = 5'd6;
   localparam logic [4:0] KIND_SEMI    = 5'd7;
   localparam logic [4:0] KIND_STAR    = 5'd8;
   localparam logic [4:0] KIND_OPER    = 5'd9;
   localparam logic [4:0] KIND_UNKNOWN = 5'd10;
   localparam logic [4:0] KIND_KW_BASE = 5'd11;

   // Keyword table. Text is left-aligned and padded with spaces to eight
   // bytes; the first character sits in the top byte.
   localparam int KW_COUNT   = 17;
   localparam int KW_MAX_LEN = 8;

   localparam logic [KW_MAX_LEN*8-1:0] KW_TEXT [KW_COUNT] = '{
      "CREATE  ", "DROP    ", "TABLE   ", "DATABASE", "PRIMARY ", "USE     ",
      "INSERT  ", "INTO    ", "VALUES  ", "SELECT  ", "FROM    ", "WHERE   ",
      "UPDATE  ", "SET     ", "DELETE  ", "INT     ", "STRING  "
   };

   localparam logic [3:0] KW_LEN [KW_COUNT] = '{
      4'd6, 4'd4, 4'd5, 4'd8, 4'd7, 4'd3, 4'd6, 4'd4, 4'd6, 4'd6, 4'd4, 4'd5,
      4'd6, 4'd3, 4'd6, 4'd3, 4'd6
   };

   // Depth of the result queue.
   localparam int RSP_DEPTH = 4;

endpackage

FILE: hdl/sqlts_kw_match.sv
// Compares the stored upper-case word prefix against every keyword at once.
module sqlts_kw_match #(
   parameter int KEYWORD_BYTES = 8
) (
   input  logic [KEYWORD_BYTES*8-1:0] word_prefix,
   input  logic [15:0]                word_length,
   output logic [4:0]                 word_kind
);

   logic hit;

   always_comb begin
      word_kind = sqlts_pkg::KIND_IDENT;
      hit       = 1'b0;
      for (int k = 0; k < sqlts_pkg::KW_COUNT; k++) begin
         hit = (word_length == 16'(sqlts_pkg::KW_LEN[k]));
         for (int i = 0; i < sqlts_pkg::KW_MAX_LEN; i++) begin
            if (i < int'(sqlts_pkg::KW_LEN[k])) begin
               hit = hit && (word_prefix[i*8 +: 8] ==
                             sqlts_pkg::KW_TEXT[k][(sqlts_pkg::KW_MAX_LEN-1-i)*8 +: 8]);
            end
         end
         if (hit) begin
            word_kind = 5'(sqlts_pkg::KIND_KW_BASE + 5'(k));
         end
      end
   end

endmodule

FILE: hdl/sqlts_rsp_fifo.sv
// Small result queue that takes up to two items per cycle and gives one.
module sqlts_rsp_fifo (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_first,
   input  sqlts_pkg::rsp_type  first_item,
   input  logic                push_second,
   input  sqlts_pkg::rsp_type  second_item,
   output logic                room,
   output logic                out_valid,
   input  logic                out_ready,
   output sqlts_pkg::rsp_type  out_item
);

   localparam int DEPTH = sqlts_pkg::RSP_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   sqlts_pkg::rsp_type slot_ff [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [1:0]         push_count;
   logic               pop;

   assign pop        = out_valid && out_ready;
   assign push_count = {1'b0, push_first} + {1'b0, push_second};
   assign wr_ptr_in  = wr_ptr_ff + PTR_W'(push_count);
   assign rd_ptr_in  = rd_ptr_ff + PTR_W'(pop);
   assign count_in   = count_ff + CNT_W'(push_count) - CNT_W'(pop);

   // Two free entries are needed before an item is taken.
   assign room      = (count_ff <= CNT_W'(DEPTH - 2));
   assign out_valid = (count_ff != '0);
   assign out_item  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_first) begin
         slot_ff[wr_ptr_ff] <= first_item;
      end
      if (push_second) begin
         slot_ff[wr_ptr_ff + PTR_W'(1)] <= second_item;
      end
   end

endmodule

FILE: hdl/sql_token_scanner_core.sv
// Channel   Direction  Handshake              Carries
// req_      in         req_valid / req_ready  one text byte or the end marker
// rsp_      out        rsp_valid / rsp_ready  one token: kind, start, length, byte
//
// An item is scanned in the cycle it is accepted, and up to two result items
// are written into a four-entry result queue; a new item can be taken every
// cycle while the queue has two free entries, so the rate is one item per
// cycle whenever tokens leave as fast as they are made. Results leave one per
// cycle, so an item that closes one token and emits another gives the output
// side two results. Reset clears the scan mode, position, open token and queue;
// there is no clearing pass. A stall on rsp_ only reaches req_ready once the
// queue holds more than two items.
module sql_token_scanner_core #(
   parameter int KEYWORD_BYTES = 8,
   parameter int POSITION_BITS = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  sqlts_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output sqlts_pkg::rsp_type rsp_payload
);

   // Scan modes.
   localparam logic [1:0] MODE_IDLE   = 2'd0;
   localparam logic [1:0] MODE_WORD   = 2'd1;
   localparam logic [1:0] MODE_NUMBER = 2'd2;
   localparam logic [1:0] MODE_STRING = 2'd3;

   localparam int IDX_W = $clog2(KEYWORD_BYTES);

   // Scanner state.
   logic [1:0]               mode_ff, mode_in;
   logic [15:0]              start_ff, start_in;
   logic [15:0]              length_ff, length_in;
   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [7:0]               prefix_ff [KEYWORD_BYTES];
   logic                     prefix_we;
   logic [IDX_W-1:0]         prefix_idx;
   logic [7:0]               prefix_data;

   logic [KEYWORD_BYTES*8-1:0] prefix_vec;
   logic [4:0]                 word_kind;

   logic                     accept;
   logic [7:0]               b;
   logic                     is_letter, is_digit, is_space, is_quote, is_word;
   logic [7:0]               b_upper;
   logic [15:0]              pos16, pos16_next;
   logic [POSITION_BITS-1:0] pos_next;
   logic [15:0]              length_sat;

   // What scanning the byte from idle would do.
   logic                     idle_emit;
   logic [4:0]               idle_kind;

   // Up to two tokens per item: the closed one, then a new or END one.
   logic                     tok_a_vld, tok_b_vld;
   sqlts_pkg::rsp_type       tok_a, tok_b;
   sqlts_pkg::rsp_type       first_item, second_item;
   logic                     push_first, push_second;
   logic                     room;

   assign accept = req_valid && req_ready;
   assign req_ready = room;

   assign b         = req_payload.text_byte;
   assign is_letter = (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
   assign is_digit  = (b >= "0" && b <= "9");
   assign is_space  = (b == " ") || (b >= 8'd9 && b <= 8'd13);
   assign is_quote  = (b == "\"");
   assign is_word   = is_letter || is_digit || (b == "_");
   assign b_upper   = (b >= "a" && b <= "z") ? b - 8'd32 : b;

   assign pos_next   = pos_ff + {{(POSITION_BITS-1){1'b0}}, 1'b1};
   assign pos16      = 16'(pos_ff);
   assign pos16_next = 16'(pos_next);
   assign length_sat = (length_ff == 16'hFFFF) ? length_ff : length_ff + 16'd1;

   always_comb begin
      for (int i = 0; i < KEYWORD_BYTES; i++) begin
         prefix_vec[i*8 +: 8] = prefix_ff[i];
      end
   end

   sqlts_kw_match #(
      .KEYWORD_BYTES(KEYWORD_BYTES)
   ) u_kw_match (
      .word_prefix(prefix_vec),
      .word_length(length_ff),
      .word_kind  (word_kind)
   );

   // One-byte token kinds; everything that is not space, word, number or
   // string start is emitted on its own.
   always_comb begin
      case (b)
         "(":           idle_kind = sqlts_pkg::KIND_LPAREN;
         ")":           idle_kind = sqlts_pkg::KIND_RPAREN;
         ",":           idle_kind = sqlts_pkg::KIND_COMMA;
         ";":           idle_kind = sqlts_pkg::KIND_SEMI;
         "*":           idle_kind = sqlts_pkg::KIND_STAR;
         "=", ">", "<": idle_kind = sqlts_pkg::KIND_OPER;
         default:       idle_kind = sqlts_pkg::KIND_UNKNOWN;
      endcase
   end

   assign idle_emit = !(is_space || is_letter || is_digit || is_quote);

   // The token that closes the open word, number or string.
   always_comb begin
      tok_a              = '0;
      tok_a.token_start  = start_ff;
      tok_a.token_length = length_ff;
      case (mode_ff)
         MODE_WORD:   tok_a.token_kind = word_kind;
         MODE_NUMBER: tok_a.token_kind = sqlts_pkg::KIND_NUMBER;
         MODE_STRING: tok_a.token_kind = sqlts_pkg::KIND_STRING;
         default:     tok_a.token_kind = sqlts_pkg::KIND_END;
      endcase
   end

   always_comb begin
      mode_in     = mode_ff;
      start_in    = start_ff;
      length_in   = length_ff;
      pos_in      = pos_ff;
      prefix_we   = 1'b0;
      prefix_idx  = '0;
      prefix_data = b_upper;
      tok_a_vld   = 1'b0;
      tok_b_vld   = 1'b0;
      tok_b       = '0;

      if (req_payload.end_of_text) begin
         // Flush whatever is open, then END at the current position.
         tok_a_vld         = (mode_ff != MODE_IDLE);
         tok_b_vld         = 1'b1;
         tok_b.token_kind  = sqlts_pkg::KIND_END;
         tok_b.token_start = pos16;
         mode_in           = MODE_IDLE;
         pos_in            = '0;
      end else begin
         pos_in = pos_next;
         if ((mode_ff == MODE_WORD && is_word) ||
             (mode_ff == MODE_NUMBER && is_digit)) begin
            length_in = length_sat;
            if (mode_ff == MODE_WORD && length_ff < 16'(KEYWORD_BYTES)) begin
               prefix_we  = 1'b1;
               prefix_idx = length_ff[IDX_W-1:0];
            end
         end else if (mode_ff == MODE_STRING) begin
            if (is_quote) begin
               tok_a_vld = 1'b1;
               mode_in   = MODE_IDLE;
            end else begin
               length_in = length_sat;
            end
         end else begin
            // Idle, or a word or number ended by this byte: close it and scan
            // the same byte from idle.
            tok_a_vld = (mode_ff != MODE_IDLE);
            mode_in   = MODE_IDLE;
            if (is_letter) begin
               mode_in   = MODE_WORD;
               start_in  = pos16;
               length_in = 16'd1;
               prefix_we = 1'b1;
            end else if (is_digit) begin
               mode_in   = MODE_NUMBER;
               start_in  = pos16;
               length_in = 16'd1;
            end else if (is_quote) begin
               // String text starts after the opening quote.
               mode_in   = MODE_STRING;
               start_in  = pos16_next;
               length_in = 16'd0;
            end
            tok_b_vld          = idle_emit;
            tok_b.token_kind   = idle_kind;
            tok_b.token_start  = pos16;
            tok_b.token_length = 16'd1;
            tok_b.single_char  = b;
         end
      end
   end

   // Pack the tokens into queue writes and mark the final one of the item.
   always_comb begin
      first_item              = tok_a_vld ? tok_a : tok_b;
      first_item.last_of_run  = !(tok_a_vld && tok_b_vld);
      second_item             = tok_b;
      second_item.last_of_run = 1'b1;
      push_first              = accept && (tok_a_vld || tok_b_vld);
      push_second             = accept && tok_a_vld && tok_b_vld;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= MODE_IDLE;
         start_ff  <= '0;
         length_ff <= '0;
         pos_ff    <= '0;
      end else if (accept) begin
         mode_ff   <= mode_in;
         start_ff  <= start_in;
         length_ff <= length_in;
         pos_ff    <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && prefix_we) begin
         prefix_ff[prefix_idx] <= prefix_data;
      end
   end

   sqlts_rsp_fifo u_rsp_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_first (push_first),
      .first_item (first_item),
      .push_second(push_second),
      .second_item(second_item),
      .room       (room),
      .out_valid  (rsp_valid),
      .out_ready  (rsp_ready),
      .out_item   (rsp_payload)
   );

endmodule
